[rtl/sha1e_pkg.sv]
// SHA-1 hash engine package: shared types, initial hash values, round constants and helpers.
// Depends on nothing; every module of the engine imports it.
`timescale 1ns / 1ps

package sha1e_pkg;

   typedef logic [4:0][31:0] digest_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        last;
   } item_type;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;
   localparam digest_type  SHA1_IV = {H4, H3, H2, H1, H0};

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE     = 8'h80;
   localparam logic [6:0] BLOCK_BYTES  = 7'd64;
   localparam logic [6:0] LEN_OFFSET   = 7'd56;
   localparam logic [6:0] LAST_ROUND   = 7'd79;
   localparam logic [2:0] WORD_BYTES   = 3'd4;
   localparam logic [2:0] LAST_INDEX   = 3'd4;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      rotl = (x << n) | (x >> (32 - n));
   endfunction

endpackage

[rtl/sha1_hash_engine.sv]
// SHA-1 hash engine top level: front queue, compression core and digest buffer.
// Depends on sha1e_pkg, sha1e_front, sha1e_core and sha1e_digest_buf.
//
// Usage: message words enter on push/full with req_message_word (first byte in
// bits 31..24), req_valid_bytes (counts above four count as four) and
// req_last_word. A word is taken when push is high and full is low. After the
// last word the engine pads the message, finishes the hash and offers the five
// digest words, index 0 first, on rsp_* while empty is low; pop takes one.
// Flow: the core takes a word in its idle state, then packs it in the append
// state; every completed 64-byte block runs 80 rounds, one per cycle in the
// single round unit, then the chaining add, and goes back to the packer.
// Padding adds one or two blocks. The core takes no new word until it is idle
// again, after packing and any compression. A two-word queue
// in front lets words wait while the core compresses. Reset clears the queues,
// loads the initial hash values and empties the output. If the receiver stalls,
// the digest waits in the output buffer; the core runs on into the next message
// and holds only once a further digest is ready.
`timescale 1ns / 1ps

module sha1_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_last_word,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_digest_index,
   output logic        rsp_digest_last
);
   import sha1e_pkg::*;

   item_type   item;
   logic       item_valid, item_take;
   logic       dig_free, dig_load;
   digest_type dig_value;

   sha1e_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_message_word (req_message_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_last_word    (req_last_word),
      .item_valid       (item_valid),
      .item_take        (item_take),
      .item             (item)
   );

   sha1e_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item       (item),
      .dig_free   (dig_free),
      .dig_load   (dig_load),
      .dig_value  (dig_value)
   );

   sha1e_digest_buf u_digest (
      .clock            (clock),
      .reset            (reset),
      .dig_load         (dig_load),
      .dig_value        (dig_value),
      .dig_free         (dig_free),
      .empty            (empty),
      .pop              (pop),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last)
   );

endmodule

[rtl/sha1e_front.sv]
// Front end of the SHA-1 engine: accepts input words, clamps the byte count and
// queues them in a two-entry buffer for the core. Depends on sha1e_pkg.
`timescale 1ns / 1ps

module sha1e_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [31:0]        req_message_word,
   input  logic [2:0]         req_valid_bytes,
   input  logic               req_last_word,
   output logic               item_valid,
   input  logic               item_take,
   output sha1e_pkg::item_type item
);
   import sha1e_pkg::*;

   item_type   slot_ff [2];
   item_type   slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   always_comb begin
      slot_in.word   = req_message_word;
      // Counts above a full word are taken as a full word.
      slot_in.nbytes = (req_valid_bytes > WORD_BYTES) ? WORD_BYTES : req_valid_bytes;
      slot_in.last   = req_last_word;
      wr_ptr_in      = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in      = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in       = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("front queue count out of range");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("front queue pointers disagree with count");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 2'd1))
      else $error("front queue lost track of a word");
`endif

endmodule

[rtl/sha1e_core.sv]
// Core of the SHA-1 engine: packs bytes into the block buffer, pads the message,
// runs the 80 rounds and hands the digest to the output buffer. Depends on sha1e_pkg.
`timescale 1ns / 1ps

module sha1e_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_take,
   input  sha1e_pkg::item_type  item,
   input  logic                 dig_free,
   output logic                 dig_load,
   output sha1e_pkg::digest_type dig_value
);
   import sha1e_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_APPEND, S_ROUND, S_ADD, S_DIGEST} state_type;
   typedef enum logic [2:0] {P_MSG, P_ONE, P_ZERO, P_LENH, P_LENL} phase_type;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [511:0] buf_ff, buf_in;
   logic [31:0] src_ff, src_in;
   logic [2:0]  src_n_ff, src_n_in;
   logic        last_ff, last_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] len_ff, len_in;
   logic [6:0]  rnd_ff, rnd_in;
   digest_type  chain_ff, chain_in;
   digest_type  work_ff, work_in;

   logic [6:0]  space, cnt_sum, zero_gap;
   logic [2:0]  take_n, zero_n;
   logic [31:0] w_new, w_cur, f_val, k_val, temp;

   assign item_take = (state_ff == S_IDLE);
   assign dig_load  = (state_ff == S_DIGEST) && dig_free;
   assign dig_value = chain_ff;

   always_comb begin
      space    = BLOCK_BYTES - {1'b0, cnt_ff};
      take_n   = ({4'b0, src_n_ff} > space) ? space[2:0] : src_n_ff;
      cnt_sum  = {1'b0, cnt_ff} + {4'b0, take_n};
      // Zero bytes still owed before the length field, at most one word a cycle.
      zero_gap = (cnt_sum < LEN_OFFSET) ? (LEN_OFFSET - cnt_sum) : (BLOCK_BYTES - cnt_sum);
      zero_n   = (zero_gap > {4'b0, WORD_BYTES}) ? WORD_BYTES : zero_gap[2:0];

      w_cur = buf_ff[511 -: 32];
      w_new = rotl(buf_ff[511 -: 32] ^ buf_ff[447 -: 32] ^ buf_ff[255 -: 32] ^
                   buf_ff[95 -: 32], 1);
      if (rnd_ff < 7'd20) begin
         f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         k_val = K0;
      end else if (rnd_ff < 7'd40) begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K1;
      end else if (rnd_ff < 7'd60) begin
         f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                 (work_ff[2] & work_ff[3]);
         k_val = K2;
      end else begin
         f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         k_val = K3;
      end
      temp = rotl(work_ff[0], 5) + f_val + work_ff[4] + w_cur + k_val;

      state_in = state_ff;
      phase_in = phase_ff;
      buf_in   = buf_ff;
      src_in   = src_ff;
      src_n_in = src_n_ff;
      last_in  = last_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      rnd_in   = rnd_ff;
      chain_in = chain_ff;
      work_in  = work_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (item_valid) begin
               src_in   = item.word;
               src_n_in = item.nbytes;
               last_in  = item.last;
               phase_in = P_MSG;
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            unique case (take_n)
               3'd1:    buf_in = {buf_ff[503:0], src_ff[31:24]};
               3'd2:    buf_in = {buf_ff[495:0], src_ff[31:16]};
               3'd3:    buf_in = {buf_ff[487:0], src_ff[31:8]};
               3'd4:    buf_in = {buf_ff[479:0], src_ff};
               default: buf_in = buf_ff;
            endcase
            src_in   = src_ff << {take_n, 3'b000};
            src_n_in = src_n_ff - take_n;
            cnt_in   = cnt_sum[5:0];
            if (phase_ff == P_MSG) begin
               len_in = len_ff + {58'b0, take_n, 3'b000};
            end
            if (cnt_sum == BLOCK_BYTES) begin
               work_in  = chain_ff;
               rnd_in   = 7'd0;
               state_in = S_ROUND;
            end else if (src_n_ff == take_n) begin
               unique case (phase_ff)
                  P_MSG: begin
                     if (last_ff) begin
                        phase_in = P_ONE;
                        src_in   = {PAD_BYTE, 24'b0};
                        src_n_in = 3'd1;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
                  P_ONE, P_ZERO: begin
                     if (cnt_sum == LEN_OFFSET) begin
                        phase_in = P_LENH;
                        src_in   = len_ff[63:32];
                        src_n_in = WORD_BYTES;
                     end else begin
                        phase_in = P_ZERO;
                        src_in   = 32'b0;
                        src_n_in = zero_n;
                     end
                  end
                  P_LENH: begin
                     phase_in = P_LENL;
                     src_in   = len_ff[31:0];
                     src_n_in = WORD_BYTES;
                  end
                  default: state_in = S_DIGEST;
               endcase
            end
         end
         S_ROUND: begin
            buf_in  = {buf_ff[479:0], w_new};
            work_in = {work_ff[3], work_ff[2], rotl(work_ff[1], 30), work_ff[0], temp};
            rnd_in  = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            for (int i = 0; i < 5; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            cnt_in   = 6'd0;
            rnd_in   = 7'd0;
            state_in = (phase_ff == P_LENL) ? S_DIGEST : S_APPEND;
         end
         S_DIGEST: begin
            if (dig_free) begin
               chain_in = SHA1_IV;
               cnt_in   = 6'd0;
               len_in   = 64'd0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= P_MSG;
         cnt_ff   <= 6'd0;
         len_ff   <= 64'd0;
         rnd_ff   <= 7'd0;
         chain_ff <= SHA1_IV;
         work_ff  <= '0;
         src_n_ff <= 3'd0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         rnd_ff   <= rnd_in;
         chain_ff <= chain_in;
         work_ff  <= work_in;
         src_n_ff <= src_n_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      src_ff <= src_in;
   end

`ifndef NO_ASSERTIONS
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND) |-> (rnd_ff <= LAST_ROUND))
      else $error("round counter ran past the last round");
   a_len_field: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPEND && phase_ff == P_LENH) |-> ({1'b0, cnt_ff} == LEN_OFFSET))
      else $error("length field not aligned in the block");
   a_digest_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIGEST && !dig_free) |=> (state_ff == S_DIGEST && $stable(chain_ff)))
      else $error("digest dropped while output buffer busy");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      (item_take && item_valid) |=> (state_ff == S_APPEND && phase_ff == P_MSG))
      else $error("word taken outside idle");
`endif

endmodule

[rtl/sha1e_digest_buf.sv]
// Output buffer of the SHA-1 engine: holds one finished digest and offers its five
// words in order on the result queue. Depends on sha1e_pkg.
`timescale 1ns / 1ps

module sha1e_digest_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  dig_load,
   input  sha1e_pkg::digest_type dig_value,
   output logic                  dig_free,
   output logic                  empty,
   input  logic                  pop,
   output logic [31:0]           rsp_digest_word,
   output logic [2:0]            rsp_digest_index,
   output logic                  rsp_digest_last
);
   import sha1e_pkg::*;

   digest_type dig_ff;
   logic       valid_ff, valid_in;
   logic [2:0] idx_ff, idx_in;
   logic       do_pop;

   assign do_pop           = pop && valid_ff;
   assign empty            = !valid_ff;
   assign dig_free         = !valid_ff;
   assign rsp_digest_word  = dig_ff[idx_ff];
   assign rsp_digest_index = idx_ff;
   assign rsp_digest_last  = (idx_ff == LAST_INDEX);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (dig_load) begin
         valid_in = 1'b1;
         idx_in   = 3'd0;
      end else if (do_pop) begin
         if (idx_ff == LAST_INDEX) begin
            valid_in = 1'b0;
            idx_in   = 3'd0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dig_load) begin
         dig_ff <= dig_value;
      end
   end

`ifndef NO_ASSERTIONS
   a_idx_range: assert property (@(posedge clock) disable iff (reset) idx_ff <= LAST_INDEX)
      else $error("digest index out of range");
   a_load_free: assert property (@(posedge clock) disable iff (reset) dig_load |-> !valid_ff)
      else $error("digest overwritten before it was delivered");
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> (idx_ff == 3'd0))
      else $error("digest delivery did not start at word zero");
`endif

endmodule
